FILE: hdl/gb5_pkg.sv
// Shared types, constants and helper functions for the 5x5 Gaussian blur stream.
// Used by the channel interfaces and by every module of the block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gb5_pkg;

   // Geometry defaults and limits
   localparam int unsigned DEF_MAX_WIDTH      = 1024;
   localparam int unsigned FRAME_WIDTH_RESET  = 640;
   localparam int unsigned FRAME_HEIGHT_RESET = 480;
   localparam int unsigned MIN_SIZE           = 3;

   // Word field widths
   localparam int PIX_W     = 8;
   localparam int ROW_W     = 16;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int COL_SUM_W = 12;

   // Line store banks: row r lives in bank r mod 5
   localparam int NUM_BANKS = 5;
   localparam int BANK_W    = 3;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 8'd1;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   // Window update for one result
   typedef enum logic [2:0] {
      WOP_NONE,
      WOP_LOAD,
      WOP_SHIFT_NEW,
      WOP_SHIFT3,
      WOP_SHIFT1
   } win_op_type;

   typedef logic [BANK_W-1:0] bank_type;

   // Vertical border reflection for the row whose column is fetched
   typedef struct packed {
      logic top0;   // row is the first of the frame
      logic top1;   // row is the second
      logic bot1;   // row is the last
      logic bot2;   // row is the second to last
   } refl_type;

   // Control of the fetch stage, one per accepted word
   typedef struct packed {
      logic                          emit;
      logic                          last;
      win_op_type                    op;
      logic                          pre_en;
      logic                          pre_idx;
      logic [NUM_BANKS-1:0]          byp;
      logic [NUM_BANKS-1:0][BANK_W-1:0] bank;
      logic [PIX_W-1:0]              pixel;
   } fetch_ctl_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } rsp_word_type;

   // b + step mod 5, step in 0..4
   function automatic bank_type bank_add(input bank_type b, input logic [2:0] step);
      logic [3:0] s;
      s = {1'b0, b} + {1'b0, step};
      if (s >= 4'(NUM_BANKS)) s = s - 4'(NUM_BANKS);
      return s[BANK_W-1:0];
   endfunction

   // Bank step (mod 5) of window entry k relative to the center row,
   // with mirrored rows folded back inside the frame.
   function automatic logic [2:0] entry_step(input logic [2:0] k, input refl_type r);
      logic [2:0] st;
      case (k)
         3'd0:    st = r.top0 ? 3'd2 : (r.top1 ? 3'd0 : 3'd3);
         3'd1:    st = r.top0 ? 3'd1 : 3'd4;
         3'd2:    st = 3'd0;
         3'd3:    st = r.bot1 ? 3'd4 : 3'd1;
         3'd4:    st = r.bot1 ? 3'd3 : (r.bot2 ? 3'd0 : 3'd2);
         default: st = 3'd0;
      endcase
      return st;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/gb5_stream_if.sv
// Valid/ready channel interfaces of the blur block: pixel requests,
// blurred results and register writes. Depends on gb5_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gb5_req_if import gb5_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             command;
   logic [PIX_W-1:0] pixel_in;
   modport source (output valid, command, pixel_in, input ready);
   modport sink   (input valid, command, pixel_in, output ready);
endinterface

interface gb5_rsp_if import gb5_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             frame_last;
   modport source (output valid, pixel_out, frame_last, input ready);
   modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

interface gb5_csr_if import gb5_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/gb5_line_store.sv
// Five-row line store: one RAM bank per row slot, one write and one
// registered read per bank each cycle. Depends on gb5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb5_line_store import gb5_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire bank_type         wr_bank,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [PIX_W-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [PIX_W-1:0] rd_data [NUM_BANKS]
);

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [PIX_W-1:0] mem [MAX_WIDTH];

      // write the incoming pixel, read the same column of every row
      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == BANK_W'(b))) begin
            mem[wr_addr] <= wr_data;
         end
         rd_data[b] <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gb5_window.sv
// Column sums, 5-column sliding window and horizontal filter stage.
// Depends on gb5_pkg (fetch_ctl_type, win_op_type).
`timescale 1ns / 1ps
`default_nettype none

module gb5_window import gb5_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fetch_ctl_type    ctl,
   input  wire logic [PIX_W-1:0] rd_data [NUM_BANKS],
   output logic                  push_valid,
   output rsp_word_type          push_word,
   output logic                  pend_emit
);

   logic [PIX_W-1:0]     tap_px [NUM_BANKS];
   logic [COL_SUM_W-1:0] col_sum;
   logic [COL_SUM_W-1:0] win_ff [NUM_BANKS];
   logic [COL_SUM_W-1:0] pre_ff [2];
   logic                 emit_ff;
   logic                 last_ff;
   logic [16:0]          h_sum;
   logic [8:0]           h_res;

   // pick each row of the column: bypassed pixel or the bank it lives in
   always_comb begin
      for (int k = 0; k < NUM_BANKS; k++) begin
         tap_px[k] = ctl.byp[k] ? ctl.pixel : rd_data[ctl.bank[k]];
      end
      col_sum = COL_SUM_W'(tap_px[0]) + (COL_SUM_W'(tap_px[1]) << 2)
              + (COL_SUM_W'(tap_px[2]) << 2) + (COL_SUM_W'(tap_px[2]) << 1)
              + (COL_SUM_W'(tap_px[3]) << 2) + COL_SUM_W'(tap_px[4]);
   end

   // window shift and row-start preload of columns 0 and 1
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else begin
         emit_ff <= ctl.emit;
      end
      last_ff <= ctl.last;
      if (ctl.pre_en) begin
         pre_ff[ctl.pre_idx] <= col_sum;
      end
      case (ctl.op)
         WOP_LOAD: begin
            win_ff[0] <= col_sum;
            win_ff[1] <= pre_ff[1];
            win_ff[2] <= pre_ff[0];
            win_ff[3] <= pre_ff[1];
            win_ff[4] <= col_sum;
         end
         WOP_SHIFT_NEW, WOP_SHIFT3, WOP_SHIFT1: begin
            for (int i = 0; i < NUM_BANKS - 1; i++) begin
               win_ff[i] <= win_ff[i+1];
            end
            // right border mirrors columns already in the window
            if (ctl.op == WOP_SHIFT3) begin
               win_ff[4] <= win_ff[3];
            end else if (ctl.op == WOP_SHIFT1) begin
               win_ff[4] <= win_ff[1];
            end else begin
               win_ff[4] <= col_sum;
            end
         end
         default: ;
      endcase
   end

   // horizontal taps, rounding and clamp
   always_comb begin
      h_sum = 17'(win_ff[0]) + (17'(win_ff[1]) << 2)
            + (17'(win_ff[2]) << 2) + (17'(win_ff[2]) << 1)
            + (17'(win_ff[3]) << 2) + 17'(win_ff[4]) + 17'd128;
      h_res = h_sum[16:8];
      push_word.pixel = (h_res > 9'd255) ? 8'd255 : h_res[PIX_W-1:0];
      push_word.last  = last_ff;
      push_valid      = emit_ff;
      pend_emit       = emit_ff;
   end

endmodule

`default_nettype wire

FILE: hdl/gb5_rsp_queue.sv
// Small result queue that decouples the filter from a stalling receiver.
// Depends on gb5_pkg and gb5_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module gb5_rsp_queue import gb5_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire rsp_word_type  push_word,
   output logic [QCNT_W-1:0]  count,
   gb5_rsp_if.source          rsp_ch
);

   rsp_word_type        data_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                pop;

   assign pop              = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.valid     = (count_ff != '0);
   assign rsp_ch.pixel_out = data_ff[rd_ptr_ff].pixel;
   assign rsp_ch.frame_last = data_ff[rd_ptr_ff].last;
   assign count            = count_ff;

   // pointers and fill level; the credit check upstream keeps it from overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)        rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
      end
      if (push_valid) begin
         data_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gaussian_blur_5x5_stream.sv
// Top level of the 5x5 binomial Gaussian blur stream: counters, fetch control,
// register port. Depends on gb5_pkg, gb5_stream_if, gb5_line_store,
// gb5_window and gb5_rsp_queue.
//
// Usage: pixels of one frame enter on req_ch in raster order with
// command = pixel; each word from the third pixel of row 2 on returns one
// blurred word on rsp_ch, in raster order, with frame_last on the final one.
// After the last pixel, send 2*W+2 drain words (command = drain), each
// returning one pending result. Out-of-order commands are dropped.
// csr_ch writes frame_width (index 0) or frame_height (index 1); a write
// restarts the frame. csr_ch is always ready; write only while idle.
// Results pass the fetch register, window and queue. Throughput: one word per
// cycle while req_ch.ready is high, set by one registered read of all five
// line store banks per word and a two-stage filter (column sums, then rows).
// A four-word result queue absorbs receiver stalls; req_ch.ready drops when
// the queue plus results in flight would fill it.
// Reset: counters cleared, frame size 640 x 480 (width clamped to
// MAX_WIDTH); the line store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_5x5_stream import gb5_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gb5_req_if.sink    req_ch,
   gb5_rsp_if.source  rsp_ch,
   gb5_csr_if.sink    csr_ch
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);

   function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] v);
      int unsigned t;
      t = 32'(v);
      if (t < MIN_SIZE)  t = MIN_SIZE;
      if (t > MAX_WIDTH) t = MAX_WIDTH;
      return WW'(t);
   endfunction

   function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] v);
      return (v < ROW_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : v;
   endfunction

   logic [WW-1:0]    width_ff, width_in;
   logic [ROW_W-1:0] height_ff, height_in;
   logic             cfg_hit;
   logic [AW-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   bank_type         in_bank_ff, in_bank_in, out_bank_ff, out_bank_in;
   fetch_ctl_type    s1_ff, s1_in;

   logic             accept, is_drain, in_done, pix_take, pix_emit, drain_emit, emit;
   logic [WW:0]      x_plus2, pre_col;
   logic             win_new;
   logic [ROW_W-1:0] h_m1, h_m2, h_m3;
   logic [AW-1:0]    rd_addr;
   bank_type         base_bank;
   refl_type         refl;
   logic             bypass_on;
   bank_type         ent_bank;

   logic [PIX_W-1:0] rd_data [NUM_BANKS];
   logic             push_valid, pend_emit;
   rsp_word_type     push_word;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W-1:0] pend;

   // credit check: queue plus results still in the pipe
   assign pend          = q_count + QCNT_W'(s1_ff.emit) + QCNT_W'(pend_emit);
   assign req_ch.ready  = pend < QCNT_W'(QUEUE_DEPTH);
   assign csr_ch.ready  = 1'b1;

   // register decode
   always_comb begin
      cfg_hit   = 1'b0;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_FRAME_WIDTH: begin
               cfg_hit  = 1'b1;
               width_in = clamp_width(csr_ch.data[CFG_W-1:0]);
            end
            CSR_FRAME_HEIGHT: begin
               cfg_hit   = 1'b1;
               height_in = clamp_height(csr_ch.data);
            end
            default: ;
         endcase
      end
   end

   // word classification
   always_comb begin
      accept     = req_ch.valid && req_ch.ready;
      is_drain   = (req_ch.command == CMD_DRAIN);
      in_done    = in_row_ff >= height_ff;
      pix_take   = accept && !is_drain && !in_done;
      pix_emit   = pix_take && ((in_row_ff >= ROW_W'(3))
                   || ((in_row_ff == ROW_W'(2)) && (in_col_ff >= AW'(2))));
      drain_emit = accept && is_drain && in_done && (out_row_ff < height_ff);
      emit       = pix_emit || drain_emit;
      x_plus2    = (WW+1)'(out_col_ff) + (WW+1)'(2);
      win_new    = x_plus2 < (WW+1)'(width_ff);
      pre_col    = x_plus2 - (WW+1)'(width_ff);
      h_m1       = height_ff - ROW_W'(1);
      h_m2       = height_ff - ROW_W'(2);
      h_m3       = height_ff - ROW_W'(3);
   end

   // fetch control: which column of which rows feeds the window next
   always_comb begin
      rd_addr   = '0;
      base_bank = '0;
      refl      = '0;
      bypass_on = 1'b0;
      ent_bank  = '0;
      s1_in     = '0;
      s1_in.pixel = req_ch.pixel_in;
      s1_in.emit  = emit;
      s1_in.last  = (out_row_ff == h_m1) && ((WW)'(out_col_ff) == width_ff - WW'(1));

      if (!emit) begin
         s1_in.op = WOP_NONE;
      end else if (out_col_ff == '0) begin
         s1_in.op = WOP_LOAD;
      end else if (win_new) begin
         s1_in.op = WOP_SHIFT_NEW;
      end else if (x_plus2 == (WW+1)'(width_ff)) begin
         s1_in.op = WOP_SHIFT3;
      end else begin
         s1_in.op = WOP_SHIFT1;
      end

      if (pix_take && (in_row_ff >= ROW_W'(2))) begin
         // column of the row two above the incoming one; incoming pixel bypassed
         rd_addr       = in_col_ff;
         s1_in.pre_en  = in_col_ff < AW'(2);
         s1_in.pre_idx = in_col_ff[0];
         base_bank     = bank_add(in_bank_ff, 3'd3);
         refl.top0     = in_row_ff == ROW_W'(2);
         refl.top1     = in_row_ff == ROW_W'(3);
         bypass_on     = 1'b1;
      end else if (drain_emit) begin
         if (win_new) begin
            rd_addr   = x_plus2[AW-1:0];
            base_bank = out_bank_ff;
            refl.top0 = out_row_ff == '0;
            refl.top1 = out_row_ff == ROW_W'(1);
            refl.bot1 = out_row_ff == h_m1;
            refl.bot2 = out_row_ff == h_m2;
         end else begin
            // row end: preload the start of the next output row
            rd_addr       = pre_col[AW-1:0];
            s1_in.pre_en  = 1'b1;
            s1_in.pre_idx = pre_col[0];
            base_bank     = bank_add(out_bank_ff, 3'd1);
            refl.top1     = out_row_ff == '0;
            refl.bot1     = out_row_ff == h_m2;
            refl.bot2     = out_row_ff == h_m3;
         end
      end

      for (int k = 0; k < NUM_BANKS; k++) begin
         ent_bank      = bank_add(base_bank, entry_step(3'(k), refl));
         s1_in.bank[k] = ent_bank;
         s1_in.byp[k]  = bypass_on && (ent_bank == in_bank_ff);
      end
   end

   // position counters
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_bank_in  = in_bank_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_bank_in = out_bank_ff;
      if (pix_take) begin
         if ((WW'(in_col_ff) + WW'(1)) == width_ff) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + ROW_W'(1);
            in_bank_in = bank_add(in_bank_ff, 3'd1);
         end else begin
            in_col_in = in_col_ff + AW'(1);
         end
      end
      if (emit) begin
         if ((WW'(out_col_ff) + WW'(1)) == width_ff) begin
            out_col_in = '0;
            if (out_row_ff == h_m1) begin
               // frame done: next pixel starts a new frame
               out_row_in  = '0;
               out_bank_in = '0;
               in_col_in   = '0;
               in_row_in   = '0;
               in_bank_in  = '0;
            end else begin
               out_row_in  = out_row_ff + ROW_W'(1);
               out_bank_in = bank_add(out_bank_ff, 3'd1);
            end
         end else begin
            out_col_in = out_col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= clamp_width(CFG_W'(FRAME_WIDTH_RESET));
         height_ff   <= clamp_height(ROW_W'(FRAME_HEIGHT_RESET));
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_bank_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_bank_ff <= '0;
         s1_ff       <= '0;
      end else begin
         s1_ff     <= s1_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         if (cfg_hit) begin
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            in_bank_ff  <= '0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            out_bank_ff <= '0;
         end else begin
            in_col_ff   <= in_col_in;
            in_row_ff   <= in_row_in;
            in_bank_ff  <= in_bank_in;
            out_col_ff  <= out_col_in;
            out_row_ff  <= out_row_in;
            out_bank_ff <= out_bank_in;
         end
      end
   end

   gb5_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
      .clock   (clock),
      .wr_en   (pix_take),
      .wr_bank (in_bank_ff),
      .wr_addr (in_col_ff),
      .wr_data (req_ch.pixel_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gb5_window u_window (
      .clock      (clock),
      .reset      (reset),
      .ctl        (s1_ff),
      .rd_data    (rd_data),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pend_emit  (pend_emit)
   );

   gb5_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .count      (q_count),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
